// ----- hdl/uqpe_pkg.sv -----
// Shared types and constants for the URL query parameter extractor.
// No dependencies; hdl/url_query_param_extractor.sv imports this package.
package uqpe_pkg;

  localparam int QUERY_LIMIT_DEF = 256;
  localparam int NAME_MAX        = 8;

  localparam int NAME_W      = 64;
  localparam int NAME_LEN_W  = 4;
  localparam int VAL_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int QERR_W      = 2;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_NAME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_NAME_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX       = 2'd2;

  // final status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MALFORMED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd4;

  // delimiters
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef struct packed {
    logic [7:0] url_char;
    logic       url_end;
  } in_word_t;

  typedef struct packed {
    logic                char_valid;
    logic [7:0]          value_char;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value_len;
  } out_word_t;

endpackage

// ----- hdl/uqpe_stream_if.sv -----
// Valid/ready stream channel carrying one word of type word_t.
// No dependencies; the word type comes in as a parameter.
interface uqpe_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/url_query_param_extractor.sv -----
// URL query parameter extractor: the result word for an accepted character is registered in the output stage.
// Throughput 1 character per cycle while the skid slot is empty; the parse state updates in the accept cycle.
// A two-entry output stage (result register plus skid) keeps chars.ready high while one result waits.
// Reset (rst, synchronous) clears the parse state, empties the output stage and sets
// wanted_name = 0, wanted_name_len = 0, value_max = 255. Depends on uqpe_pkg, uqpe_stream_if.
module url_query_param_extractor #(
  parameter int QUERY_LIMIT = uqpe_pkg::QUERY_LIMIT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  uqpe_stream_if.sink                            chars,
  uqpe_stream_if.source                          results,
  input  logic                                   cfg_we,
  input  logic [uqpe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [uqpe_pkg::NAME_W-1:0]            cfg_data
);
  import uqpe_pkg::*;

  localparam int QCNT_W = $clog2(QUERY_LIMIT + 1);

  // configuration registers
  logic [NAME_W-1:0]     wanted_name;
  logic [NAME_LEN_W-1:0] wanted_name_len;
  logic [VAL_W-1:0]      value_max;

  // parse state
  logic                  query_started;
  logic                  in_name;
  logic                  still_matching;
  logic [NAME_LEN_W-1:0] match_pos;
  logic [QCNT_W-1:0]     query_count;
  logic [VAL_W-1:0]      value_count;
  logic                  pairs_finished;
  logic [STATUS_W-1:0]   pair_error;
  logic [QERR_W-1:0]     query_error;

  logic                  query_started_next;
  logic                  in_name_next;
  logic                  still_matching_next;
  logic [NAME_LEN_W-1:0] match_pos_next;
  logic [QCNT_W-1:0]     query_count_next;
  logic [VAL_W-1:0]      value_count_next;
  logic                  pairs_finished_next;
  logic [STATUS_W-1:0]   pair_error_next;
  logic [QERR_W-1:0]     query_error_next;

  // output stage: head register and skid register
  logic      head_valid;
  out_word_t head;
  logic      skid_valid;
  out_word_t skid;

  logic                  accept;
  logic                  emit;
  logic                  push;
  logic                  pop;
  logic [NAME_LEN_W-1:0] name_len;
  logic [7:0]            ch;
  logic                  last;
  logic [STATUS_W-1:0]   final_status;
  out_word_t             word_next;

  // Room remains as long as the skid slot is empty.
  assign chars.ready   = !skid_valid;
  assign accept        = chars.valid && chars.ready;
  assign ch            = chars.data.url_char;
  assign last          = chars.data.url_end;
  assign results.valid = head_valid;
  assign results.data  = head;
  assign pop           = head_valid && results.ready;

  // A requested name longer than the compare window counts as the window.
  assign name_len = (wanted_name_len > NAME_LEN_W'(NAME_MAX)) ?
                    NAME_LEN_W'(NAME_MAX) : wanted_name_len;

  // Character parse: one pass of flag and counter updates per character.
  always_comb begin
    query_started_next  = query_started;
    in_name_next        = in_name;
    still_matching_next = still_matching;
    match_pos_next      = match_pos;
    query_count_next    = query_count;
    value_count_next    = value_count;
    pairs_finished_next = pairs_finished;
    pair_error_next     = pair_error;
    query_error_next    = query_error;
    emit                = 1'b0;

    if (!query_started) begin
      // skip the path until the first '?'
      if (ch == CH_QMARK) begin
        query_started_next = 1'b1;
      end
    end else if (ch == CH_QMARK) begin
      // a second '?' is a query error; keep the first one seen
      if (query_error == '0) begin
        query_error_next = QERR_W'(ST_MALFORMED);
      end
    end else if (query_error == '0) begin
      if (query_count >= QCNT_W'(QUERY_LIMIT)) begin
        query_error_next = QERR_W'(ST_NOT_FOUND);
      end else begin
        query_count_next = query_count + QCNT_W'(1);
        if (pair_error == ST_OK && !pairs_finished) begin
          if (ch == CH_AMP) begin
            if (in_name) begin
              pair_error_next = ST_MALFORMED;
            end else if (still_matching) begin
              // end of the matching value: stop scanning pairs
              pairs_finished_next = 1'b1;
            end else begin
              in_name_next        = 1'b1;
              still_matching_next = 1'b1;
              match_pos_next      = '0;
            end
          end else if (ch == CH_EQ) begin
            if (!in_name) begin
              pair_error_next = ST_MALFORMED;
            end else begin
              if (still_matching && match_pos != name_len) begin
                still_matching_next = 1'b0;
                match_pos_next      = '0;
              end
              in_name_next = 1'b0;
            end
          end else if (in_name) begin
            if (still_matching) begin
              if (match_pos < name_len &&
                  ch == wanted_name[match_pos[2:0]*8 +: 8]) begin
                match_pos_next = match_pos + NAME_LEN_W'(1);
              end else begin
                still_matching_next = 1'b0;
                match_pos_next      = '0;
              end
            end
          end else if (still_matching) begin
            if (value_count >= value_max) begin
              pair_error_next = ST_TOO_LONG;
            end else begin
              value_count_next = value_count + VAL_W'(1);
              emit             = 1'b1;
            end
          end
        end
      end
    end

    // Query errors rank first, then pair errors, then how the input ended.
    if (query_error_next != '0) begin
      final_status = STATUS_W'(query_error_next);
    end else if (pair_error_next != ST_OK) begin
      final_status = pair_error_next;
    end else if (pairs_finished_next) begin
      final_status = ST_OK;
    end else if (in_name_next) begin
      final_status = ST_INCOMPLETE;
    end else if (!still_matching_next) begin
      final_status = ST_NOT_FOUND;
    end else begin
      final_status = ST_OK;
    end

    word_next.char_valid = emit;
    word_next.value_char = emit ? ch : 8'd0;
    word_next.done_res   = last;
    word_next.status     = last ? final_status : ST_OK;
    word_next.value_len  = (last && final_status == ST_OK) ? value_count_next : '0;

    // last character: drop the parse state for the next URL
    if (last) begin
      query_started_next  = 1'b0;
      in_name_next        = 1'b1;
      still_matching_next = 1'b1;
      match_pos_next      = '0;
      query_count_next    = '0;
      value_count_next    = '0;
      pairs_finished_next = 1'b0;
      pair_error_next     = ST_OK;
      query_error_next    = '0;
    end
  end

  // A result word is produced for value characters and for the last character.
  assign push = accept && (emit || last);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_name     <= '0;
      wanted_name_len <= '0;
      value_max       <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WANTED_NAME:     wanted_name     <= cfg_data;
        REG_WANTED_NAME_LEN: wanted_name_len <= cfg_data[NAME_LEN_W-1:0];
        REG_VALUE_MAX:       value_max       <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // parse state: advance on every accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      query_started  <= 1'b0;
      in_name        <= 1'b1;
      still_matching <= 1'b1;
      match_pos      <= '0;
      query_count    <= '0;
      value_count    <= '0;
      pairs_finished <= 1'b0;
      pair_error     <= ST_OK;
      query_error    <= '0;
    end else if (accept) begin
      query_started  <= query_started_next;
      in_name        <= in_name_next;
      still_matching <= still_matching_next;
      match_pos      <= match_pos_next;
      query_count    <= query_count_next;
      value_count    <= value_count_next;
      pairs_finished <= pairs_finished_next;
      pair_error     <= pair_error_next;
      query_error    <= query_error_next;
    end
  end

  // Output stage: fill the head first, spill into skid when the head is stalled,
  // refill the head from skid when the head word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        head_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        head <= skid;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        head <= word_next;
      end else begin
        skid <= word_next;
      end
    end
  end

  // The skid slot only ever holds a word behind a waiting head word.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid word held with empty head");

  // The last character returns the parser to its idle state.
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (!query_started && query_count == '0 && value_count == '0))
    else $error("parse state not cleared after last character");

  // A value character is only passed out inside a matching value.
  a_emit_in_value: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |-> (query_started && !in_name && still_matching && !pairs_finished))
    else $error("value character outside a matching value");

  // Status and length are only reported on the final word.
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head.done_res) |-> (head.status == ST_OK && head.value_len == '0))
    else $error("status reported before the last character");

endmodule

// ----- verif/url_query_param_extractor_test.sv -----
// Self-checking testbench for url_query_param_extractor: drives URL characters, predicts every
// result word and compares it field by field. Depends on all three files in hdl/.
module url_query_param_extractor_test;
  import uqpe_pkg::*;

  localparam int SETTLE_CYCLES  = 6;     // output stage depth plus latency, with margin
  localparam int RX_HOLD_CYCLES = 60;    // long receiver hold-off for the fill-up test
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on either side
  localparam int QUERY_LIMIT    = QUERY_LIMIT_DEF;

  typedef logic [7:0] url_t[$];

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NAME_W-1:0]    cfg_data;

  uqpe_stream_if #(.word_t(in_word_t))  chars ();
  uqpe_stream_if #(.word_t(out_word_t)) results ();

  url_query_param_extractor DUT (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 10 time units, high then low.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the extractor: configuration, parse state and pending result words
  // ---------------------------------------------------------------------------
  logic [63:0] want_name = '0;
  logic [3:0]  want_len  = '0;
  logic [7:0]  val_limit = 8'd255;

  bit          qry_open;       // first '?' seen
  bit          reading_name;   // inside a pair name, before '='
  bit          name_hit;       // current name still equals the wanted name
  int unsigned hit_pos;        // characters of the wanted name matched so far
  int unsigned qry_bytes;      // query characters counted against the limit
  int unsigned val_bytes;      // value characters passed out
  bit          scan_done;      // '&' after the matching value stops pair scanning
  logic [2:0]  pair_fault;
  logic [2:0]  qry_fault;

  out_word_t   expected_words[$];
  int          fail_count;

  // stimulus controls
  bit          tx_gaps_on;
  bit          rx_gaps_on;
  bit          hold_req;
  url_t        url_buf;

  function automatic void clear_parse_state();
    qry_open     = 1'b0;
    reading_name = 1'b1;
    name_hit     = 1'b1;
    hit_pos      = 0;
    qry_bytes    = 0;
    val_bytes    = 0;
    scan_done    = 1'b0;
    pair_fault   = ST_OK;
    qry_fault    = ST_OK;
  endfunction

  function automatic int unsigned used_name_len();
    return (want_len > NAME_MAX) ? NAME_MAX : want_len;
  endfunction

  // Advance the pair parser by one query character; return 1 for a value character to pass out.
  function automatic bit pair_char(logic [7:0] c);
    int unsigned nlen;
    nlen = used_name_len();
    if (c == CH_AMP) begin
      if (reading_name) pair_fault = ST_MALFORMED;
      else if (name_hit) scan_done = 1'b1;
      else begin
        reading_name = 1'b1;
        name_hit     = 1'b1;
        hit_pos      = 0;
      end
      return 1'b0;
    end
    if (c == CH_EQ) begin
      if (!reading_name) pair_fault = ST_MALFORMED;
      else begin
        if (name_hit && hit_pos != nlen) begin
          name_hit = 1'b0;
          hit_pos  = 0;
        end
        reading_name = 1'b0;
      end
      return 1'b0;
    end
    if (reading_name) begin
      if (name_hit) begin
        if (hit_pos < nlen && c == want_name[8*(hit_pos%8) +: 8]) hit_pos++;
        else begin
          name_hit = 1'b0;
          hit_pos  = 0;
        end
      end
      return 1'b0;
    end
    if (name_hit) begin
      if (val_bytes >= val_limit) begin
        pair_fault = ST_TOO_LONG;
        return 1'b0;
      end
      val_bytes++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the result word (if any) for one accepted character and queue it.
  function automatic void predict_char(logic [7:0] c, logic last);
    bit        emit;
    out_word_t w;
    logic [2:0] fin;
    emit = 1'b0;
    if (!qry_open) begin
      if (c == CH_QMARK) qry_open = 1'b1;
    end else if (c == CH_QMARK) begin
      if (qry_fault == ST_OK) qry_fault = ST_MALFORMED;
    end else if (qry_fault == ST_OK) begin
      if (qry_bytes >= QUERY_LIMIT) qry_fault = ST_NOT_FOUND;
      else begin
        qry_bytes++;
        if (pair_fault == ST_OK && !scan_done) emit = pair_char(c);
      end
    end
    if (!emit && !last) return;

    w            = '0;
    w.char_valid = emit;
    w.value_char = emit ? c : 8'd0;
    w.done_res   = last;
    if (last) begin
      // query errors outrank pair errors; a finished scan is good unless an error is pending
      if (qry_fault != ST_OK)       fin = qry_fault;
      else if (pair_fault != ST_OK) fin = pair_fault;
      else if (scan_done)           fin = ST_OK;
      else if (reading_name)        fin = ST_INCOMPLETE;
      else if (!name_hit)           fin = ST_NOT_FOUND;
      else                          fin = ST_OK;
      w.status    = fin;
      w.value_len = (fin == ST_OK) ? val_bytes[7:0] : 8'd0;
      clear_parse_state();
    end
    expected_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int  hold_left;
    int  stall_left;
    bit  rdy;
    hold_left  = 0;
    stall_left = 0;
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      results.ready <= rdy;
    end
  end

  // Compare one field of a result word; flag any difference or unknown bit.
  task automatic check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", field, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t act_w;
    if (!rst && results.valid && results.ready) begin
      act_w = results.data;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", act_w);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        check_field("char_valid", 8'(exp_w.char_valid), 8'(act_w.char_valid));
        check_field("value_char", exp_w.value_char, act_w.value_char);
        check_field("done_res",   8'(exp_w.done_res),   8'(act_w.done_res));
        check_field("status",     8'(exp_w.status),     8'(act_w.status));
        check_field("value_len",  exp_w.value_len,  act_w.value_len);
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (chars.valid && chars.ready) || (results.valid && results.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("url_query_param_extractor_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Character side
  // ---------------------------------------------------------------------------

  // Offer one character, optionally after a short gap, and hold it until accepted.
  task automatic send_char(logic [7:0] c, logic last);
    in_word_t w;
    w.url_char = c;
    w.url_end  = last;
    @(negedge clk);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      chars.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    chars.valid <= 1'b1;
    chars.data  <= w;
    do @(posedge clk); while (!chars.ready);
    predict_char(c, last);
  endtask

  task automatic send_url();
    for (int i = 0; i < url_buf.size(); i++) send_char(url_buf[i], i == url_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    url_buf.delete();
    for (int i = 0; i < s.len(); i++) url_buf.push_back(s[i]);
    send_url();
  endtask

  // Drop valid, wait until every predicted word has arrived, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    chars.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers; narrow registers get junk in their unused upper bits.
  task automatic write_config(logic [63:0] name, logic [3:0] len, logic [7:0] vmax);
    logic [63:0] d;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WANTED_NAME;
    cfg_data  <= name;
    @(negedge clk);
    d = {$urandom, $urandom};
    d[3:0] = len;
    cfg_index <= REG_WANTED_NAME_LEN;
    cfg_data  <= d;
    @(negedge clk);
    d = {$urandom, $urandom};
    d[7:0] = vmax;
    cfg_index <= REG_VALUE_MAX;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    want_name = name;
    want_len  = len;
    val_limit = vmax;
  endtask

  // ---------------------------------------------------------------------------
  // URL generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] path_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QMARK);
    return b;
  endfunction

  // any byte that is not a delimiter
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QMARK || b == CH_AMP || b == CH_EQ);
    return b;
  endfunction

  // name characters lean on the wanted name so that near misses are common
  function automatic logic [7:0] name_byte();
    int k;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 1) == 1) return want_name[8*k +: 8];
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [63:0] random_abc_name();
    logic [63:0] n;
    for (int i = 0; i < 8; i++) n[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
    return n;
  endfunction

  // Build a mostly well-formed URL with random content; a share is broken on purpose.
  task automatic build_random_url();
    int unsigned nlen;
    int          npairs;
    int          n;
    nlen = used_name_len();
    url_buf.delete();
    repeat ($urandom_range(0, 3)) url_buf.push_back(path_byte());
    if ($urandom_range(0, 19) != 0) url_buf.push_back(CH_QMARK);
    npairs = $urandom_range(1, 4);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) url_buf.push_back(CH_AMP);
      case ($urandom_range(0, 4))
        0, 1: begin
          for (int i = 0; i < nlen; i++) url_buf.push_back(want_name[8*i +: 8]);
        end
        2: begin
          // prefix of the wanted name plus one more character
          n = $urandom_range(0, nlen);
          for (int i = 0; i < n; i++) url_buf.push_back(want_name[8*i +: 8]);
          url_buf.push_back(name_byte());
        end
        default: begin
          repeat ($urandom_range(0, 3)) url_buf.push_back(name_byte());
        end
      endcase
      // end inside a name now and then
      if (p == npairs - 1 && $urandom_range(0, 9) == 0) break;
      if ($urandom_range(0, 19) != 0) url_buf.push_back(CH_EQ);
      repeat ($urandom_range(0, 6)) url_buf.push_back(plain_byte());
    end
    if ($urandom_range(0, 24) == 0) url_buf.push_back(CH_QMARK);
    if (url_buf.size() == 0) url_buf.push_back(plain_byte());
    // corrupt one character with any byte value, delimiters included
    if ($urandom_range(0, 9) == 0)
      url_buf[$urandom_range(0, url_buf.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Random URLs until about n_items characters went in; pause for a full drain now and then.
  task automatic test_random_urls(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      build_random_url();
      sent += url_buf.size();
      send_url();
      if ($urandom_range(0, 14) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // Reset values: empty wanted name, so a pair with an empty name matches.
  task automatic test_reset_defaults();
    send_text("?=v");
    test_random_urls(100);
  endtask

  // Short hand-picked URLs, one per status and delimiter case.
  task automatic test_directed_cases();
    write_config(64'h61, 4'd1, 8'd1);
    // extreme byte values: a zero in the path, 0xFF as the value
    url_buf.delete();
    url_buf.push_back(8'h00);
    url_buf.push_back(CH_QMARK);
    url_buf.push_back(8'h61);
    url_buf.push_back(CH_EQ);
    url_buf.push_back(8'hFF);
    send_url();
    send_text("x");      // no query at all
    send_text("?&");     // '&' while reading a name
    send_text("?b==");   // '=' inside a value
    send_text("?a=xy");  // value longer than the limit
    send_text("?b=x");   // name never found
    send_text("??");     // second '?'
    wait_drained();
  endtask

  // Several register settings, extremes included.
  task automatic test_name_configs();
    write_config(64'h6261, 4'd2, 8'd255);
    test_random_urls(120);
    write_config('1, 4'd8, 8'd4);
    test_random_urls(120);
    write_config(random_abc_name(), 4'd15, 8'd0);  // length above the maximum counts as full
    test_random_urls(120);
    write_config(64'h626163, 4'd3, 8'd3);
    test_random_urls(120);
  endtask

  // Query length right at the limit, then one past it with a pair error already pending.
  task automatic test_query_limit();
    write_config(64'h6261, 4'd2, 8'd255);
    url_buf.delete();
    url_buf.push_back(CH_QMARK);
    url_buf.push_back(8'h61);
    url_buf.push_back(8'h62);
    url_buf.push_back(CH_EQ);
    repeat (QUERY_LIMIT - 3) url_buf.push_back(plain_byte());
    send_url();
    url_buf.delete();
    url_buf.push_back(CH_QMARK);
    url_buf.push_back(CH_AMP);
    repeat (QUERY_LIMIT) url_buf.push_back(plain_byte());
    send_url();
    wait_drained();
  endtask

  // Hold the result side off while long matching values keep coming, so the input stalls.
  task automatic test_backpressure();
    write_config(64'h6261, 4'd2, 8'd255);
    hold_req = 1'b1;
    repeat (3) begin
      url_buf.delete();
      url_buf.push_back(CH_QMARK);
      url_buf.push_back(8'h61);
      url_buf.push_back(8'h62);
      url_buf.push_back(CH_EQ);
      repeat (30) url_buf.push_back(plain_byte());
      send_url();
    end
    wait_drained();
  endtask

  // Last stretch: random setting, no gaps on either side.
  task automatic test_quiet_tail();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_config(random_abc_name(), 4'($urandom_range(0, 8)), 8'($urandom_range(0, 10)));
    test_random_urls(200);
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_WANTED_NAME;
    cfg_data    = '0;
    chars.valid = 1'b0;
    chars.data  = '0;
    tx_gaps_on  = 1'b1;
    rx_gaps_on  = 1'b1;
    hold_req    = 1'b0;
    fail_count  = 0;
    clear_parse_state();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_name_configs();
    test_query_limit();
    test_backpressure();
    test_quiet_tail();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("url_query_param_extractor_test: clean");
    end else begin
      $display("url_query_param_extractor_test: errors");
    end
    $finish;
  end

endmodule
